### rtl/assert_macros.svh
// assert_macros.svh: shorthand macros for the concurrent checks in the CSV field extractor.
// No dependencies; define NO_ASSERTIONS to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset
`define CSV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
// Check a property on every rising edge, reset included
`define CSV_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define CSV_ASSERT(lbl, clk, rst, prop)
`define CSV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/csvfe_pkg.sv
// csvfe_pkg: shared types, codes and sizes of the CSV field extractor.
// No dependencies; imported by every module of the block.
package csvfe_pkg;

   // Width of the field and character counters
   localparam int COUNT_WIDTH = 16;
   // Entries of the queue between front and back end
   localparam int TOKEN_DEPTH = 4;
   localparam int TOKEN_PTR_W = $clog2(TOKEN_DEPTH);
   // Largest counter value, held in 32 bits for comparisons
   localparam logic [31:0] COUNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

   localparam logic [7:0] QUOTE_CHAR     = 8'h22;
   localparam logic [7:0] BACKSLASH_CHAR = 8'h5c;

   // Register indexes
   localparam logic [1:0] CSR_DELIMITER = 2'd0;
   localparam logic [1:0] CSR_MERGE     = 2'd1;
   localparam logic [1:0] CSR_ESCAPE    = 2'd2;

   // Escape modes
   localparam logic [1:0] ESC_NONE      = 2'd0;
   localparam logic [1:0] ESC_DOUBLED   = 2'd1;
   localparam logic [1:0] ESC_BACKSLASH = 2'd2;

   // Result kinds and line status codes
   localparam logic       KIND_CHAR       = 1'b0;
   localparam logic       KIND_STATUS     = 1'b1;
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TRUNC    = 2'd1;
   localparam logic [1:0] STATUS_BAD_PARM = 2'd2;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [2:0] {
      PH_LINE, PH_START, PH_FIELD, PH_CLOSED, PH_MERGE, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      HOLD_NONE, HOLD_QUOTE, HOLD_BSL, HOLD_SWALLOW
   } hold_type;

   typedef struct packed {
      logic [7:0] delimiter;
      logic       merge;
      logic [1:0] escape;
   } cfg_type;

   // One classified input item, as handed from front to back end
   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_value;
      logic       line_end;
      logic       line_first;
      logic       bad_param;
      count_type  capacity;
   } token_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  out_char;
      logic [1:0]  status;
      logic [15:0] char_count;
      logic        last;
   } result_type;

endpackage

### rtl/csvfe_front.sv
// csvfe_front: scanner that splits the line into fields and picks out the wanted field's bytes.
// Depends on csvfe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module csvfe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  csvfe_pkg::cfg_type    cfg,
   input  logic                  accept,
   input  logic [7:0]            line_byte,
   input  logic                  end_of_line,
   input  logic                  empty_line,
   input  logic [15:0]           field_number,
   input  logic [15:0]           buffer_length,
   output csvfe_pkg::token_type  token
);
   import csvfe_pkg::*;

   typedef struct packed {
      phase_type  phase;
      count_type  field_index;
      logic       in_quotes;
      hold_type   held;
      logic       char_valid;
      logic [7:0] char_value;
   } scan_type;

   phase_type phase_ff, phase_in;
   count_type field_index_ff, field_index_in;
   logic      in_quotes_ff, in_quotes_in;
   hold_type  held_ff, held_in;
   count_type target_ff, target_in;
   logic      bad_ff, bad_in;

   logic      line_first;
   logic      line_end;
   logic      bad_now;
   count_type target_now;
   count_type capacity_now;
   scan_type  scan;

   // Clamp a sampled 16-bit value to the counter range
   function automatic count_type saturate_count(input logic [15:0] value);
      logic [31:0] wide;
      wide = {16'd0, value};
      if (wide > COUNT_MAX32) return COUNT_MAX32[COUNT_WIDTH-1:0];
      return wide[COUNT_WIDTH-1:0];
   endfunction

   // Pass a character on when it belongs to the wanted field
   function automatic scan_type deliver(scan_type s, logic [7:0] b, count_type tgt);
      if (s.field_index == tgt) begin
         s.char_valid = 1'b1;
         s.char_value = b;
      end
      return s;
   endfunction

   function automatic scan_type finish_field(scan_type s, cfg_type c, count_type tgt);
      s.in_quotes = 1'b0;
      s.held      = HOLD_NONE;
      if (s.field_index == tgt) begin
         s.phase = PH_DONE;
      end else begin
         s.field_index = s.field_index + count_type'(1);
         s.phase       = c.merge ? PH_MERGE : PH_START;
      end
      return s;
   endfunction

   function automatic scan_type plain_byte(scan_type s, logic [7:0] b, cfg_type c,
                                           count_type tgt);
      if (s.in_quotes && b == QUOTE_CHAR) begin
         s.phase = PH_CLOSED;
      end else if (!s.in_quotes && b == c.delimiter) begin
         s = finish_field(s, c, tgt);
      end else begin
         s = deliver(s, b, tgt);
      end
      return s;
   endfunction

   function automatic scan_type field_byte(scan_type s, logic [7:0] b, cfg_type c,
                                           count_type tgt);
      if (c.escape == ESC_DOUBLED && b == QUOTE_CHAR) begin
         if (!s.in_quotes && c.delimiter != QUOTE_CHAR) begin
            s      = deliver(s, QUOTE_CHAR, tgt);
            s.held = HOLD_SWALLOW;
         end else begin
            s.held = HOLD_QUOTE;
         end
      end else if (c.escape == ESC_BACKSLASH && b == BACKSLASH_CHAR) begin
         s.held = HOLD_BSL;
      end else begin
         s = plain_byte(s, b, c, tgt);
      end
      return s;
   endfunction

   // First byte of a field: an opening quote makes it quoted
   function automatic scan_type start_byte(scan_type s, logic [7:0] b, cfg_type c,
                                           count_type tgt);
      s.held  = HOLD_NONE;
      s.phase = PH_FIELD;
      if (b == QUOTE_CHAR) begin
         s.in_quotes = 1'b1;
      end else begin
         s.in_quotes = 1'b0;
         s = field_byte(s, b, c, tgt);
      end
      return s;
   endfunction

   // Bytes seen outside the body of a field
   function automatic scan_type outer_byte(scan_type s, logic [7:0] b, cfg_type c,
                                           count_type tgt);
      case (s.phase)
         PH_MERGE: begin
            if (b != c.delimiter) s = start_byte(s, b, c, tgt);
         end
         PH_START: begin
            s = start_byte(s, b, c, tgt);
         end
         PH_CLOSED: begin
            if (b == c.delimiter) s = finish_field(s, c, tgt);
         end
         default: begin
         end
      endcase
      return s;
   endfunction

   function automatic scan_type take_byte(scan_type s, logic [7:0] b, cfg_type c,
                                          count_type tgt);
      hold_type h;
      if (s.phase == PH_FIELD) begin
         h      = s.held;
         s.held = HOLD_NONE;
         case (h)
            HOLD_BSL: begin
               s = deliver(s, b, tgt);
            end
            HOLD_SWALLOW: begin
               if (b != QUOTE_CHAR) s = field_byte(s, b, c, tgt);
            end
            HOLD_QUOTE: begin
               if (b == QUOTE_CHAR) begin
                  s = deliver(s, QUOTE_CHAR, tgt);
               end else begin
                  // The held quote closes the field; rescan this byte after it
                  s = plain_byte(s, QUOTE_CHAR, c, tgt);
                  s = outer_byte(s, b, c, tgt);
               end
            end
            default: begin
               s = field_byte(s, b, c, tgt);
            end
         endcase
      end else begin
         s = outer_byte(s, b, c, tgt);
      end
      return s;
   endfunction

   // Next state: sample the line parameters, scan the byte, flush a held escape
   always_comb begin
      line_first   = (phase_ff == PH_LINE);
      line_end     = end_of_line | empty_line;
      capacity_now = saturate_count(buffer_length);
      target_now   = line_first ? saturate_count(field_number) : target_ff;
      bad_now      = line_first ? ((target_now == '0) || (capacity_now == '0)) : bad_ff;

      scan.phase       = phase_ff;
      scan.field_index = field_index_ff;
      scan.in_quotes   = in_quotes_ff;
      scan.held        = held_ff;
      scan.char_valid  = 1'b0;
      scan.char_value  = '0;
      if (line_first) begin
         scan.field_index = count_type'(1);
         scan.in_quotes   = 1'b0;
         scan.held        = HOLD_NONE;
         scan.phase       = bad_now ? PH_DONE : PH_START;
      end
      if (!empty_line) scan = take_byte(scan, line_byte, cfg, target_now);
      // A quote or backslash still held at line end is scanned as a plain byte
      if (line_end && scan.phase == PH_FIELD) begin
         if (scan.held == HOLD_QUOTE) begin
            scan.held = HOLD_NONE;
            scan      = plain_byte(scan, QUOTE_CHAR, cfg, target_now);
         end else if (scan.held == HOLD_BSL) begin
            scan.held = HOLD_NONE;
            scan      = plain_byte(scan, BACKSLASH_CHAR, cfg, target_now);
         end
      end

      phase_in       = line_end ? PH_LINE : scan.phase;
      field_index_in = line_end ? '0 : scan.field_index;
      in_quotes_in   = line_end ? 1'b0 : scan.in_quotes;
      held_in        = line_end ? HOLD_NONE : scan.held;
      target_in      = target_now;
      bad_in         = bad_now;
   end

   // Outputs: build the transaction for the back end
   always_comb begin
      token.char_valid = scan.char_valid;
      token.char_value = scan.char_value;
      token.line_end   = line_end;
      token.line_first = line_first;
      token.bad_param  = bad_now;
      token.capacity   = capacity_now;
   end

   // Advance the scanner on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LINE;
         field_index_ff <= '0;
         in_quotes_ff   <= 1'b0;
         held_ff        <= HOLD_NONE;
         target_ff      <= '0;
         bad_ff         <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         field_index_ff <= field_index_in;
         in_quotes_ff   <= in_quotes_in;
         held_ff        <= held_in;
         target_ff      <= target_in;
         bad_ff         <= bad_in;
      end
   end

   // Field numbering starts at one and never passes the wanted field
   `CSV_ASSERT(a_index_nonzero, clock, reset, (phase_ff != PH_LINE) |-> (field_index_ff != '0))
   `CSV_ASSERT(a_index_bounded, clock, reset,
      (phase_ff != PH_LINE && !bad_ff) |-> (field_index_ff <= target_ff))

endmodule

### rtl/csvfe_token_fifo.sv
// csvfe_token_fifo: short queue of classified transactions between front and back end.
// Depends on csvfe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module csvfe_token_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  csvfe_pkg::token_type  push_token,
   output logic                  full,
   input  logic                  pop,
   output csvfe_pkg::token_type  pop_token,
   output logic                  empty
);
   import csvfe_pkg::*;

   localparam logic [TOKEN_PTR_W-1:0] LAST_PTR  = TOKEN_PTR_W'(TOKEN_DEPTH - 1);
   localparam logic [TOKEN_PTR_W:0]   DEPTH_CNT = (TOKEN_PTR_W + 1)'(TOKEN_DEPTH);

   token_type                entries_ff [TOKEN_DEPTH];
   logic [TOKEN_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [TOKEN_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [TOKEN_PTR_W:0]     count_ff, count_in;
   logic                     do_push, do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);
   assign pop_token = entries_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;

   // Step pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_token;
   end

   // Occupancy agrees with the pointer distance
   `CSV_ASSERT(a_count_matches_ptrs, clock, reset,
      (count_ff != '0 && count_ff != DEPTH_CNT) |-> (wr_ptr_ff != rd_ptr_ff))

endmodule

### rtl/csvfe_back.sv
// csvfe_back: applies the buffer limit, counts characters, writes results to the output queue.
// Depends on csvfe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module csvfe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tok_empty,
   input  csvfe_pkg::token_type  token,
   output logic                  tok_pop,
   output logic                  empty,
   input  logic                  pop,
   output logic                  kind,
   output logic [7:0]            out_char,
   output logic [1:0]            status,
   output logic [15:0]           char_count,
   output logic                  last
);
   import csvfe_pkg::*;

   localparam int              OUT_DEPTH = 2;
   localparam logic [1:0]      OUT_FULL  = 2'(OUT_DEPTH);

   count_type  written_ff, written_in;
   count_type  cap_ff, cap_in;
   logic       trunc_ff, trunc_in;
   logic       char_done_ff, char_done_in;

   result_type out_entries_ff [OUT_DEPTH];
   logic       out_wr_ff, out_rd_ff;
   logic [1:0] out_count_ff, out_count_in;

   count_type  cap_now;
   logic       room;
   logic       char_pending;
   logic       emit_char;
   logic       trunc_now;
   logic       split;
   logic       push_result;
   logic       out_full;
   logic       advance;
   logic       do_push, do_pop;
   result_type result;

   // Map the counter onto the 16-bit count field
   function automatic logic [15:0] to_char_count(input count_type c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[15:0];
   endfunction

   // Decide what the head transaction produces this cycle
   always_comb begin
      cap_now      = token.line_first ? token.capacity : cap_ff;
      room         = (written_ff < cap_now);
      char_pending = !tok_empty && token.char_valid && !char_done_ff;
      emit_char    = char_pending && room;
      trunc_now    = trunc_ff | (char_pending & ~room);
      // A character and a status from one transaction go out as separate results
      split        = emit_char && token.line_end;
      push_result  = !tok_empty && (emit_char || token.line_end);
      out_full     = (out_count_ff == OUT_FULL);
      advance      = !tok_empty && (!push_result || !out_full);
      tok_pop      = advance && !split;
      do_push      = advance && push_result;
      do_pop       = pop && !empty;
   end

   // Build the result for the output queue
   always_comb begin
      if (emit_char) begin
         result.kind       = KIND_CHAR;
         result.out_char   = token.char_value;
         result.status     = STATUS_OK;
         result.char_count = to_char_count(written_ff + count_type'(1));
         result.last       = 1'b0;
      end else begin
         result.kind       = KIND_STATUS;
         result.out_char   = '0;
         result.char_count = to_char_count(written_ff);
         result.last       = 1'b1;
         if (token.bad_param)  result.status = STATUS_BAD_PARM;
         else if (trunc_now)   result.status = STATUS_TRUNC;
         else                  result.status = STATUS_OK;
      end
   end

   // Line counters: hold unless the head transaction advances
   always_comb begin
      written_in   = written_ff;
      cap_in       = cap_ff;
      trunc_in     = trunc_ff;
      char_done_in = char_done_ff;
      if (advance) begin
         if (token.line_first) cap_in = token.capacity;
         if (emit_char) written_in = written_ff + count_type'(1);
         trunc_in = trunc_now;
         if (split) char_done_in = 1'b1;
         if (tok_pop) begin
            char_done_in = 1'b0;
            if (token.line_end) begin
               written_in = '0;
               trunc_in   = 1'b0;
            end
         end
      end
   end

   // Output queue occupancy
   always_comb begin
      case ({do_push, do_pop})
         2'b10:   out_count_in = out_count_ff + 1'b1;
         2'b01:   out_count_in = out_count_ff - 1'b1;
         default: out_count_in = out_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         cap_ff       <= '0;
         trunc_ff     <= 1'b0;
         char_done_ff <= 1'b0;
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= '0;
      end else begin
         written_ff   <= written_in;
         cap_ff       <= cap_in;
         trunc_ff     <= trunc_in;
         char_done_ff <= char_done_in;
         out_count_ff <= out_count_in;
         if (do_push) out_wr_ff <= ~out_wr_ff;
         if (do_pop)  out_rd_ff <= ~out_rd_ff;
      end
   end

   // Store the result
   always_ff @(posedge clock) begin
      if (do_push) out_entries_ff[out_wr_ff] <= result;
   end

   assign empty      = (out_count_ff == '0);
   assign kind       = out_entries_ff[out_rd_ff].kind;
   assign out_char   = out_entries_ff[out_rd_ff].out_char;
   assign status     = out_entries_ff[out_rd_ff].status;
   assign char_count = out_entries_ff[out_rd_ff].char_count;
   assign last       = out_entries_ff[out_rd_ff].last;

   // Characters never outrun the sampled capacity
   `CSV_ASSERT(a_within_capacity, clock, reset, (written_ff <= cap_ff))
   // A split transaction stays at the head for its status
   `CSV_ASSERT(a_split_holds_head, clock, reset,
      (advance && split) |=> (char_done_ff && !tok_empty && token.line_end))

endmodule

### rtl/csv_field_extractor_unit.sv
// csv_field_extractor_unit: top level of the CSV field extractor; holds the control registers.
// Depends on csvfe_pkg, csvfe_front, csvfe_token_fifo and csvfe_back.
//
// Streams one CSV line a byte per transaction and returns the characters of one chosen field,
// followed by a status result that closes the line. The block takes one byte every cycle while
// full is low: the front end scans each byte combinationally and queues a transaction for the
// back end, which writes one result per cycle, while there is room, into a two-entry output
// queue. A byte that yields a character and also ends the line gives two back-end results. The
// four-entry transaction queue absorbs short runs of these, so full rises when the result side
// stalls or when such bytes keep arriving back to back (a run of one-byte lines that each
// deliver a character). A result passes through the transaction queue and the output queue.
// Control registers may be written whenever the block is idle; csr_ready is always high.
module csv_field_extractor_unit (
   input  logic        clock,
   input  logic        reset,
   // Control register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   // Line bytes
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_line_byte,
   input  logic        req_end_of_line,
   input  logic        req_empty_line,
   input  logic [15:0] req_field_number,
   input  logic [15:0] req_buffer_length,
   // Results
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_out_char,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_char_count,
   output logic        rsp_last
);
   import csvfe_pkg::*;

   cfg_type   cfg_ff;
   logic      accept;
   logic      csr_write;
   token_type front_token;
   token_type head_token;
   logic      tok_empty;
   logic      tok_pop;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign accept    = push & ~full;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter <= 8'd44;
         cfg_ff.merge     <= 1'b0;
         cfg_ff.escape    <= ESC_DOUBLED;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DELIMITER: cfg_ff.delimiter <= csr_data;
            CSR_MERGE:     cfg_ff.merge     <= csr_data[0];
            CSR_ESCAPE:    cfg_ff.escape    <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   csvfe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (accept),
      .line_byte     (req_line_byte),
      .end_of_line   (req_end_of_line),
      .empty_line    (req_empty_line),
      .field_number  (req_field_number),
      .buffer_length (req_buffer_length),
      .token         (front_token)
   );

   csvfe_token_fifo u_token_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_token (front_token),
      .full       (full),
      .pop        (tok_pop),
      .pop_token  (head_token),
      .empty      (tok_empty)
   );

   csvfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_empty  (tok_empty),
      .token      (head_token),
      .tok_pop    (tok_pop),
      .empty      (empty),
      .pop        (pop),
      .kind       (rsp_kind),
      .out_char   (rsp_out_char),
      .status     (rsp_status),
      .char_count (rsp_char_count),
      .last       (rsp_last)
   );

endmodule
